FILE: src/aes128_block_cipher_top_macros.svh
// Assertion macros for the AES-128 modules, used by the control module.
`ifndef AES128_BLOCK_CIPHER_TOP_MACROS_SVH
`define AES128_BLOCK_CIPHER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that a condition implies a consequence in the same cycle.
`define AES_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define AES_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/aes_pkg.sv
`timescale 1ns / 1ps
package aes_pkg;

	localparam int NROUNDS    = 10;
	localparam int NKEYS      = NROUNDS + 1;
	localparam int RND_W      = 4;
	localparam int IDX_W      = 2;
	localparam int KEY_W      = 64;
	localparam int BLK_W      = 128;
	localparam int IN_TDATA_W = 136;
	localparam int OUT_TDATA_W = 128;

	localparam logic [IDX_W-1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [IDX_W-1:0] REG_KEY_LOW  = 2'd1;
	localparam logic [RND_W-1:0] LAST_RND     = 4'd10;

	typedef enum logic [1:0] {
		ST_EXPAND,
		ST_IDLE,
		ST_ROUND
	} state_t;

	typedef struct packed {
		logic             exp_en;
		logic [RND_W-1:0] exp_idx;
		logic             load;
		logic             round_en;
		logic             dec;
		logic             last;
		logic [RND_W-1:0] key_idx;
		logic             out_load;
	} cmd_t;

	typedef struct packed {
		logic out_full;
	} status_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	// Round constant for key expansion step 1 to 10.
	function automatic logic [7:0] rcon(input logic [RND_W-1:0] idx);
		logic [7:0] v;
		case (idx)
			4'd1:    v = 8'h01;
			4'd2:    v = 8'h02;
			4'd3:    v = 8'h04;
			4'd4:    v = 8'h08;
			4'd5:    v = 8'h10;
			4'd6:    v = 8'h20;
			4'd7:    v = 8'h40;
			4'd8:    v = 8'h80;
			4'd9:    v = 8'h1b;
			4'd10:   v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// State byte k sits at bits 127-8k down.
	function automatic logic [7:0] get_b(input logic [BLK_W-1:0] s, input int k);
		return s[BLK_W-1-8*k -: 8];
	endfunction

	function automatic logic [BLK_W-1:0] sub_bytes(input logic [BLK_W-1:0] s);
		logic [BLK_W-1:0] t;
		for (int k = 0; k < 16; k++) t[BLK_W-1-8*k -: 8] = SBOX[get_b(s, k)];
		return t;
	endfunction

	function automatic logic [BLK_W-1:0] inv_sub_bytes(input logic [BLK_W-1:0] s);
		logic [BLK_W-1:0] t;
		for (int k = 0; k < 16; k++) t[BLK_W-1-8*k -: 8] = INV_SBOX[get_b(s, k)];
		return t;
	endfunction

	// Rotate row r left by r, or right by r for the inverse.
	function automatic logic [BLK_W-1:0] shift_rows(input logic [BLK_W-1:0] s,
			input logic inv);
		logic [BLK_W-1:0] t;
		int src;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				src = inv ? ((c + 3 * r) & 3) : ((c + r) & 3);
				t[BLK_W-1-8*(r*4+c) -: 8] = get_b(s, r * 4 + src);
			end
		end
		return t;
	endfunction

	function automatic logic [BLK_W-1:0] mix_cols(input logic [BLK_W-1:0] s);
		logic [BLK_W-1:0] t;
		logic [7:0] a [4];
		logic [7:0] x [4];
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) begin
				a[j] = get_b(s, j * 4 + c);
				x[j] = xtime(a[j]);
			end
			for (int i = 0; i < 4; i++) begin
				t[BLK_W-1-8*(i*4+c) -: 8] = x[i] ^ x[(i+1)&3] ^ a[(i+1)&3]
					^ a[(i+2)&3] ^ a[(i+3)&3];
			end
		end
		return t;
	endfunction

	function automatic logic [BLK_W-1:0] inv_mix_cols(input logic [BLK_W-1:0] s);
		logic [BLK_W-1:0] t;
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m9, mb, md, me;
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) begin
				a[j]  = get_b(s, j * 4 + c);
				x2[j] = xtime(a[j]);
				x4[j] = xtime(x2[j]);
				x8[j] = xtime(x4[j]);
			end
			for (int i = 0; i < 4; i++) begin
				me = x8[i] ^ x4[i] ^ x2[i];
				mb = x8[(i+1)&3] ^ x2[(i+1)&3] ^ a[(i+1)&3];
				md = x8[(i+2)&3] ^ x4[(i+2)&3] ^ a[(i+2)&3];
				m9 = x8[(i+3)&3] ^ a[(i+3)&3];
				t[BLK_W-1-8*(i*4+c) -: 8] = me ^ mb ^ md ^ m9;
			end
		end
		return t;
	endfunction

	// Lay round-key word c into column c, its top byte into row 0.
	function automatic logic [BLK_W-1:0] key_state(input logic [BLK_W-1:0] k);
		logic [BLK_W-1:0] t;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				t[BLK_W-1-8*(r*4+c) -: 8] = k[BLK_W-1-32*c-8*r -: 8];
			end
		end
		return t;
	endfunction

	// One key expansion step: four words of the next round key.
	function automatic logic [BLK_W-1:0] key_next(input logic [BLK_W-1:0] k,
			input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, rot, tmp;
		w0  = k[127:96];
		w1  = k[95:64];
		w2  = k[63:32];
		w3  = k[31:0];
		rot = {w3[23:0], w3[31:24]};
		tmp = {SBOX[rot[31:24]] ^ rc, SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]};
		w0  = w0 ^ tmp;
		w1  = w1 ^ w0;
		w2  = w2 ^ w1;
		w3  = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

FILE: src/aes_ctrl.sv
`timescale 1ns / 1ps
`include "aes128_block_cipher_top_macros.svh"
module aes_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic                          in_dec,
	input  logic                          wr_en,
	input  logic [aes_pkg::IDX_W-1:0]     wr_index,
	input  logic                          m_tready,
	input  aes_pkg::status_t              status,
	output aes_pkg::cmd_t                 cmd
);

	aes_pkg::state_t              state_q, state_d;
	logic [aes_pkg::RND_W-1:0]    cnt_q, cnt_d;
	logic                         dec_q, dec_d;
	logic                         key_wr;
	logic                         accept;

	// Only the two key registers restart expansion.
	assign key_wr = wr_en && (wr_index == aes_pkg::REG_KEY_HIGH ||
		wr_index == aes_pkg::REG_KEY_LOW);
	assign accept = s_tvalid && s_tready;

	// Hold state, counter and direction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aes_pkg::ST_EXPAND;
			cnt_q   <= '0;
			dec_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			dec_q   <= dec_d;
		end
	end

	// Sequence expansion, then one round per cycle; the last round stalls while the output is full and not taken.
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		dec_d    = dec_q;
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			aes_pkg::ST_EXPAND: begin
				cmd.exp_en  = 1'b1;
				cmd.exp_idx = cnt_q;
				if (cnt_q == aes_pkg::LAST_RND) begin
					state_d = aes_pkg::ST_IDLE;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			aes_pkg::ST_IDLE: begin
				s_tready    = !key_wr;
				cmd.dec     = in_dec;
				cmd.key_idx = in_dec ? aes_pkg::LAST_RND : '0;
				if (accept) begin
					cmd.load = 1'b1;
					dec_d    = in_dec;
					cnt_d    = 4'd1;
					state_d  = aes_pkg::ST_ROUND;
				end
			end
			aes_pkg::ST_ROUND: begin
				cmd.dec     = dec_q;
				cmd.last    = (cnt_q == aes_pkg::LAST_RND);
				cmd.key_idx = dec_q ? (aes_pkg::LAST_RND - cnt_q) : cnt_q;
				if (!cmd.last) begin
					cmd.round_en = 1'b1;
					cnt_d        = cnt_q + 1'b1;
				end else if (!status.out_full || m_tready) begin
					cmd.round_en = 1'b1;
					cmd.out_load = 1'b1;
					cnt_d        = '0;
					state_d      = aes_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = aes_pkg::ST_EXPAND;
				cnt_d   = '0;
			end
		endcase
		if (key_wr) begin
			state_d = aes_pkg::ST_EXPAND;
			cnt_d   = '0;
		end
	end

	`AES_ASSERT_NEXT(a_accept_starts, clk, arst_n, accept, state_q == aes_pkg::ST_ROUND && cnt_q == 4'd1)
	`AES_ASSERT_NEXT(a_done_idle, clk, arst_n, cmd.out_load && !key_wr, state_q == aes_pkg::ST_IDLE)
	`AES_ASSERT_SAME(a_round_range, clk, arst_n, state_q == aes_pkg::ST_ROUND, cnt_q >= 4'd1 && cnt_q <= aes_pkg::LAST_RND)

endmodule

FILE: src/aes_dp.sv
`timescale 1ns / 1ps
module aes_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [aes_pkg::BLK_W-1:0]          in_blk,
	input  logic                               wr_en,
	input  logic [aes_pkg::IDX_W-1:0]          wr_index,
	input  logic [aes_pkg::KEY_W-1:0]          wr_data,
	input  logic                               m_tready,
	input  aes_pkg::cmd_t                      cmd,
	output aes_pkg::status_t                   status,
	output logic                               m_tvalid,
	output logic [aes_pkg::BLK_W-1:0]          res_blk
);

	logic [aes_pkg::KEY_W-1:0] key_high_q, key_low_q;
	logic [aes_pkg::BLK_W-1:0] rk_q [aes_pkg::NKEYS];
	logic [aes_pkg::BLK_W-1:0] cur_q;
	logic [aes_pkg::BLK_W-1:0] st_q;
	logic [aes_pkg::BLK_W-1:0] out_q;
	logic                      out_full_q;
	logic [aes_pkg::BLK_W-1:0] kn;
	logic [aes_pkg::BLK_W-1:0] rkey;
	logic [aes_pkg::BLK_W-1:0] fwd_sr, fwd_mc, inv_ak, inv_mc, rnd_out;

	// Hold the cipher key registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (wr_en) begin
			if (wr_index == aes_pkg::REG_KEY_HIGH) key_high_q <= wr_data;
			if (wr_index == aes_pkg::REG_KEY_LOW)  key_low_q  <= wr_data;
		end
	end

	// Advance key expansion by one round key; step 0 takes the cipher key itself.
	assign kn = (cmd.exp_idx == '0) ? {key_high_q, key_low_q}
		: aes_pkg::key_next(cur_q, aes_pkg::rcon(cmd.exp_idx));

	always_ff @(posedge clk) begin
		if (cmd.exp_en) begin
			rk_q[cmd.exp_idx] <= kn;
			cur_q             <= kn;
		end
	end

	// Select the round key in state layout.
	assign rkey = aes_pkg::key_state(rk_q[cmd.key_idx]);

	// Build one forward or inverse round.
	always_comb begin
		fwd_sr = aes_pkg::shift_rows(aes_pkg::sub_bytes(st_q), 1'b0);
		fwd_mc = cmd.last ? fwd_sr : aes_pkg::mix_cols(fwd_sr);
		inv_ak = aes_pkg::inv_sub_bytes(aes_pkg::shift_rows(st_q, 1'b1)) ^ rkey;
		inv_mc = cmd.last ? inv_ak : aes_pkg::inv_mix_cols(inv_ak);
		rnd_out = cmd.dec ? inv_mc : (fwd_mc ^ rkey);
	end

	// Load the whitened block or step a round; drop the last into the output.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			st_q <= in_blk ^ rkey;
		end else if (cmd.round_en) begin
			st_q <= rnd_out;
		end
		if (cmd.out_load) out_q <= rnd_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_full_q <= 1'b1;
		end else if (m_tready) begin
			out_full_q <= 1'b0;
		end
	end

	assign status.out_full = out_full_q;
	assign m_tvalid        = out_full_q;
	assign res_blk         = out_q;

endmodule

FILE: src/aes128_block_cipher_top.sv
`timescale 1ns / 1ps
// AES-128 ECB encrypt/decrypt, one shared round unit.
// m_tvalid rises once the last round is loaded into the output register, which
// holds the result until m_tready takes it. Each block is a load with key add,
// then 10 rounds; the next input beat is taken only after the last round has
// gone to the output register. Key expansion runs after reset and after each
// key write; no input beat is taken meanwhile. Reset loads the all-zero key.
module aes128_block_cipher_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// mode [0], block_high [64:1], block_low [128:65], zero pad [135:129]
	input  logic [aes_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// result_high [63:0], result_low [127:64]
	output logic [aes_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                wr_en,
	input  logic [aes_pkg::IDX_W-1:0]           wr_index,
	input  logic [aes_pkg::KEY_W-1:0]           wr_data
);

	aes_pkg::cmd_t               cmd;
	aes_pkg::status_t            status;
	logic [aes_pkg::BLK_W-1:0]   in_blk;
	logic [aes_pkg::BLK_W-1:0]   res_blk;

	// Unpack the block: high half holds state bytes 0 to 7.
	assign in_blk  = {s_tdata[64:1], s_tdata[128:65]};
	assign m_tdata = {res_blk[63:0], res_blk[127:64]};

	aes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.in_dec   (s_tdata[0]),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	aes_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_blk   (in_blk),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status),
		.m_tvalid (m_tvalid),
		.res_blk  (res_blk)
	);

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;

	localparam logic       MODE_ENC    = 1'b0;
	localparam logic       MODE_DEC    = 1'b1;
	localparam logic [aes_pkg::IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [aes_pkg::IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int         IDLE_LIMIT  = 5000;
	localparam int         TAIL_CYCLES = 24;

	typedef struct {
		logic [63:0] res_hi;
		logic [63:0] res_lo;
	} block_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	// mode [0], block_high [64:1], block_low [128:65], zero pad [135:129]
	logic [aes_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	// result_high [63:0], result_low [127:64]
	logic [aes_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                            wr_en;
	logic [aes_pkg::IDX_W-1:0]       wr_index;
	logic [aes_pkg::KEY_W-1:0]       wr_data;

	aes128_block_cipher_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data)
	);

	// Cipher model: key registers, expanded schedule, working state
	logic [63:0] key_hi_q;
	logic [63:0] key_lo_q;
	logic [31:0] sched [44];
	logic [7:0]  st [16];

	block_t pending_blocks [$];
	int     mismatches;
	int     idle_cycles;
	int     rx_ready_pct;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int n = 0; n < 8; n++) begin
			if (b[0]) acc ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
			b = b >> 1;
		end
		return acc;
	endfunction

	function automatic void build_schedule();
		logic [31:0] t;
		logic [7:0]  rc;
		sched[0] = key_hi_q[63:32];
		sched[1] = key_hi_q[31:0];
		sched[2] = key_lo_q[63:32];
		sched[3] = key_lo_q[31:0];
		rc = 8'h01;
		for (int i = 4; i < 44; i++) begin
			t = sched[i-1];
			if ((i & 3) == 0) begin
				t = {t[23:0], t[31:24]};
				t = {aes_pkg::SBOX[t[31:24]] ^ rc, aes_pkg::SBOX[t[23:16]],
					aes_pkg::SBOX[t[15:8]], aes_pkg::SBOX[t[7:0]]};
				rc = gf_mult(rc, 8'h02);
			end
			sched[i] = sched[i-4] ^ t;
		end
	endfunction

	// XOR round key rd into the state, word c into column c
	function automatic void add_round_key(input int rd);
		logic [31:0] w;
		for (int c = 0; c < 4; c++) begin
			w = sched[4*rd+c];
			st[c]    ^= w[31:24];
			st[4+c]  ^= w[23:16];
			st[8+c]  ^= w[15:8];
			st[12+c] ^= w[7:0];
		end
	endfunction

	function automatic void substitute(input logic inv);
		for (int k = 0; k < 16; k++)
			st[k] = inv ? aes_pkg::INV_SBOX[st[k]] : aes_pkg::SBOX[st[k]];
	endfunction

	// Rotate row r left by r (dir 1) or right by r (dir 3)
	function automatic void rotate_rows(input int dir);
		logic [7:0] t [16];
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++) t[r*4+c] = st[r*4+((c+dir*r)&3)];
		st = t;
	endfunction

	function automatic void mix_columns(input logic [31:0] coefs);
		logic [7:0] a [4];
		logic [7:0] v;
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) a[j] = st[j*4+c];
			for (int i = 0; i < 4; i++) begin
				v = 8'h00;
				for (int j = 0; j < 4; j++)
					v ^= gf_mult(coefs[31-8*((j-i)&3) -: 8], a[j]);
				st[i*4+c] = v;
			end
		end
	endfunction

	function automatic block_t cipher_block(input logic mode, input logic [63:0] hi,
			input logic [63:0] lo);
		block_t r;
		for (int k = 0; k < 8; k++) begin
			st[k]   = hi[63-8*k -: 8];
			st[k+8] = lo[63-8*k -: 8];
		end
		if (mode == MODE_DEC) begin
			add_round_key(10);
			for (int rd = 9; rd > 0; rd--) begin
				rotate_rows(3);
				substitute(1'b1);
				add_round_key(rd);
				mix_columns(32'h0e0b0d09);
			end
			rotate_rows(3);
			substitute(1'b1);
			add_round_key(0);
		end else begin
			add_round_key(0);
			for (int rd = 1; rd < 10; rd++) begin
				substitute(1'b0);
				rotate_rows(1);
				mix_columns(32'h02030101);
				add_round_key(rd);
			end
			substitute(1'b0);
			rotate_rows(1);
			add_round_key(10);
		end
		for (int k = 0; k < 8; k++) begin
			r.res_hi[63-8*k -: 8] = st[k];
			r.res_lo[63-8*k -: 8] = st[k+8];
		end
		return r;
	endfunction

	// Send one block; tvalid stays high, the caller drops it in gaps
	task automatic send_block(input logic mode, input logic [63:0] hi, input logic [63:0] lo);
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, lo, hi, mode};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_blocks.push_back(cipher_block(mode, hi, lo));
	endtask

	task automatic sender_gap();
		int n;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) n = 0;
		else if (pick < 90) n = $urandom_range(1, 3);
		else n = $urandom_range(8, 40);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_blocks.size() != 0) @(posedge clk);
	endtask

	// Write one key register, then hold until expansion is done
	task automatic write_key(input logic [aes_pkg::IDX_W-1:0] idx, input logic [63:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == aes_pkg::REG_KEY_HIGH) key_hi_q = val;
		else if (idx == aes_pkg::REG_KEY_LOW) key_lo_q = val;
		if (idx == aes_pkg::REG_KEY_HIGH || idx == aes_pkg::REG_KEY_LOW) build_schedule();
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Accept result beats and compare against the oldest expectation
	always @(posedge clk) begin
		block_t want;
		if (m_tvalid && m_tready) begin
			if (pending_blocks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", m_tdata);
			end else begin
				want = pending_blocks.pop_front();
				if (m_tdata[63:0] !== want.res_hi || m_tdata[127:64] !== want.res_lo) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected hi %h lo %h, got hi %h lo %h",
							want.res_hi, want.res_lo, m_tdata[63:0], m_tdata[127:64]);
				end
			end
		end
	end

	// Drive backpressure: random stalls with an occasional long one, below 100 pct ready
	int stall_left;
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 199) == 0 && rx_ready_pct < 100) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(10, 50);
		end else begin
			m_tready <= ($urandom_range(0, 99) < rx_ready_pct);
		end
	end

	// Watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic test_reset_key();
		send_block(MODE_ENC, 64'h0, 64'h0);
		send_block(MODE_DEC, 64'h0, 64'h0);
		send_block(MODE_ENC, '1, '1);
		send_block(MODE_DEC, '1, '1);
		send_block(MODE_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
		wait_drained();
	endtask

	task automatic test_key_extremes();
		write_key(aes_pkg::REG_KEY_HIGH, 64'h0001020304050607);
		write_key(aes_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
		send_block(MODE_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block(MODE_DEC, 64'h0011223344556677, 64'h8899aabbccddeeff);
		wait_drained();
		// spare indexes must leave the key untouched
		write_key(REG_SPARE_A, '1);
		write_key(REG_SPARE_B, 64'h5a5a5a5a5a5a5a5a);
		send_block(MODE_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block(MODE_DEC, '1, 64'h0);
		wait_drained();
		write_key(aes_pkg::REG_KEY_HIGH, '1);
		write_key(aes_pkg::REG_KEY_LOW, '1);
		send_block(MODE_ENC, 64'h0, 64'h0);
		send_block(MODE_DEC, 64'h0, '1);
		send_block(MODE_ENC, '1, '1);
		wait_drained();
		write_key(aes_pkg::REG_KEY_LOW, 64'h0);
		send_block(MODE_ENC, 64'h8000000000000000, 64'h1);
		send_block(MODE_DEC, 64'h1, 64'h8000000000000000);
		wait_drained();
	endtask

	task automatic test_random_traffic(input int items, input int pct);
		rx_ready_pct = pct;
		write_key(aes_pkg::REG_KEY_HIGH, rand64());
		write_key(aes_pkg::REG_KEY_LOW, rand64());
		for (int i = 0; i < items; i++) begin
			send_block(logic'($urandom_range(0, 1)), rand64(), rand64());
			if (pct < 100) sender_gap();
		end
		wait_drained();
	endtask

	// Hold the sender until every result has drained, then resume
	task automatic test_sender_pause();
		rx_ready_pct = 40;
		for (int i = 0; i < 6; i++) send_block(logic'(i & 1), rand64(), rand64());
		wait_drained();
		for (int i = 0; i < 6; i++) send_block(logic'(~i & 1), rand64(), rand64());
		wait_drained();
	endtask

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		wr_en        = 1'b0;
		wr_index     = aes_pkg::REG_KEY_HIGH;
		wr_data      = '0;
		mismatches   = 0;
		idle_cycles  = 0;
		rx_ready_pct = 80;
		key_hi_q     = '0;
		key_lo_q     = '0;
		build_schedule();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_key();
		test_key_extremes();
		test_sender_pause();
		test_random_traffic(150, 100);
		test_random_traffic(250, 85);
		test_random_traffic(250, 50);
		test_random_traffic(250, 95);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_blocks.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/aes_pkg.sv
src/aes_ctrl.sv
src/aes_dp.sv
src/aes128_block_cipher_top.sv
dv/testbench.sv
